/* rtl/core/bvsw_pkg.sv */
// Shared types and constants for the bounded varint stream writer.
// No dependencies; imported by the controller, the datapath and the top level.
package bvsw_pkg;

	localparam logic [7:0] SIGN_BIT  = 8'h40;
	localparam logic [7:0] LOW6_MASK = 8'h3F;
	localparam logic [7:0] CONT_BIT  = 8'h80;
	localparam logic [7:0] LOW7_MASK = 8'h7F;

	localparam logic [31:0] CAPACITY_RESET = 32'd4096;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture the input value
		logic check;  // latch length for the emit sequence
		logic emit;   // put the next encoded byte in the output register
		logic fail;   // put the no-space result in the output register
	} bvsw_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic fits;       // encoding fits between position and capacity
		logic last_byte;  // the byte about to be emitted is the final one
		logic out_free;   // output register can take a beat this cycle
	} bvsw_sts_t;

endpackage

/* rtl/core/bvsw_ctrl.sv */
// Controller state machine for the bounded varint stream writer.
// Depends on bvsw_pkg for the command and status structs.
module bvsw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bvsw_pkg::bvsw_sts_t sts,
	output bvsw_pkg::bvsw_cmd_t cmd
);
	import bvsw_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_FAIL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign cmd.load  = (state_q == ST_IDLE) && in_valid;
	assign cmd.check = (state_q == ST_CHECK);
	assign cmd.emit  = (state_q == ST_EMIT) && sts.out_free;
	assign cmd.fail  = (state_q == ST_FAIL) && sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sts.fits ? ST_EMIT : ST_FAIL;
			end
			ST_EMIT: begin
				// advance to idle once the final byte has gone out
				if (sts.out_free && sts.last_byte) state_d = ST_IDLE;
			end
			ST_FAIL: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.fail) |-> sts.out_free)
		else $error("result loaded while the output register was occupied");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last_byte) |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle after the final byte");

	a_check_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_CHECK) && in_stall)
		else $error("accepted item did not proceed to the fit check");

endmodule

/* rtl/core/bvsw_dp.sv */
// Datapath of the bounded varint stream writer: magnitude, length, fit test,
// byte assembly, write position, capacity and the output register. Uses bvsw_pkg.
module bvsw_dp #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [31:0]                   cfg_data,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [7:0]                    out_byte,
	output logic [31:0]                   byte_offset,
	output logic                          last,
	output logic                          status,
	output logic                          overflow_seen,
	input  bvsw_pkg::bvsw_cmd_t           cmd,
	output bvsw_pkg::bvsw_sts_t           sts
);
	import bvsw_pkg::*;

	localparam int MAX_LEN = 1 + VALUE_WIDTH / 7;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   sign_q;
	logic [LEN_W-1:0]       rem_q;
	logic                   first_q;
	logic [31:0]            pos_q;
	logic [31:0]            cap_q;
	logic                   ovf_q;

	logic [VALUE_WIDTH-1:0] in_mag;
	logic [MAX_LEN-1:0]     chunk_nz;
	logic [LEN_W-1:0]       len;
	logic [32:0]            end_pos;
	logic                   cont;
	logic [7:0]             enc_byte;

	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic [31:0]            byte_offset_q;
	logic                   last_q;
	logic                   status_q;
	logic                   overflow_q;

	// the most negative value negates to itself, which reads as 2^(W-1) unsigned
	assign in_mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	// chunk k is nonzero when any bit at or above its start is set; the flags are
	// monotonic, so their count gives the number of bytes after the first
	always_comb begin
		chunk_nz = '0;
		for (int k = 1; k < MAX_LEN; k++) begin
			chunk_nz[k] = |(mag_q >> (6 + 7 * (k - 1)));
		end
	end

	assign len     = LEN_W'(1) + LEN_W'($countones(chunk_nz));
	assign end_pos = {1'b0, pos_q} + 33'(len);

	assign sts.fits      = (end_pos <= {1'b0, cap_q});
	assign sts.last_byte = (rem_q == LEN_W'(1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign cont = !sts.last_byte;

	always_comb begin
		if (first_q) begin
			enc_byte = (mag_q[7:0] & LOW6_MASK) | (sign_q ? SIGN_BIT : 8'h00);
		end else begin
			enc_byte = mag_q[7:0] & LOW7_MASK;
		end
		if (cont) enc_byte = enc_byte | CONT_BIT;
	end

	// item and encoder state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q  <= in_mag;
			sign_q <= value[VALUE_WIDTH-1];
		end else if (cmd.emit) begin
			mag_q <= first_q ? (mag_q >> 6) : (mag_q >> 7);
		end
		if (cmd.check) begin
			rem_q   <= len;
			first_q <= 1'b1;
		end else if (cmd.emit) begin
			rem_q   <= rem_q - LEN_W'(1);
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cap_q <= CAPACITY_RESET;
			ovf_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) cap_q <= cfg_data;
			if (cmd.emit) pos_q <= pos_q + 32'd1;
			if (cmd.fail) ovf_q <= 1'b1;
		end
	end

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.fail) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q    <= enc_byte;
			byte_offset_q <= pos_q;
			last_q        <= !cont;
			status_q      <= 1'b0;
			overflow_q    <= ovf_q;
		end else if (cmd.fail) begin
			out_byte_q    <= 8'h00;
			byte_offset_q <= pos_q;
			last_q        <= 1'b1;
			status_q      <= 1'b1;
			overflow_q    <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign byte_offset   = byte_offset_q;
	assign last          = last_q;
	assign status        = status_q;
	assign overflow_seen = overflow_q;

	a_fail_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (last_q && overflow_q && (out_byte_q == 8'h00)))
		else $error("no-space beat must be final, flagged and carry a zero byte");

	a_pos_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (pos_q == $past(pos_q) + 32'd1))
		else $error("write position did not advance by one per emitted byte");

	a_fail_keeps_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fail |=> $stable(pos_q) && ovf_q)
		else $error("failed write moved the position or missed the overflow flag");

endmodule

/* rtl/core/bounded_varint_stream_writer.sv */
// Bounded sign-magnitude varint stream writer. Takes one VALUE_WIDTH-bit
// two's complement value per beat and emits its 1 to 1+VALUE_WIDTH/7 encoded
// bytes (1 to 5 for 32 bits), one byte per beat, each with its buffer offset;
// when the encoding does not fit within the capacity a single no-space beat
// is emitted instead and the sticky overflow flag is set. Items are handled
// one at a time: each is captured, tested for fit, then its bytes go out
// one after another through the single output register that the byte
// emitter feeds, which holds a byte while the output is stalled. The
// capacity register is written over the cfg channel, which is always ready;
// write it only while the block is idle.
module bounded_varint_stream_writer #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic [31:0]                   byte_offset,
	output logic                          last,
	output logic                          status,
	output logic                          overflow_seen,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [31:0]                   cfg_data
);
	import bvsw_pkg::*;

	bvsw_cmd_t cmd;
	bvsw_sts_t sts;

	assign cfg_ready = 1'b1;

	bvsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bvsw_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.value         (value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.byte_offset   (byte_offset),
		.last          (last),
		.status        (status),
		.overflow_seen (overflow_seen),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

/* dv/bvsw_encode_checker.sv */
// Checker for the bounded varint stream writer: watches the input, output and
// capacity channels, predicts the encoded beats and compares them in order.
// Stand-alone; instantiated beside the block by tb_top.
module bvsw_encode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	input  logic [31:0] byte_offset,
	input  logic        last,
	input  logic        status,
	input  logic        overflow_seen,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          mismatch_count,
	output int          beats_pending,
	output logic [31:0] next_offset
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0]  SIGN_FLAG    = 8'h40;
	localparam logic [7:0]  FIRST_MASK   = 8'h3F;
	localparam logic [7:0]  MORE_FLAG    = 8'h80;
	localparam logic [7:0]  NEXT_MASK    = 8'h7F;
	localparam logic [31:0] CAPACITY_RST = 32'd4096;

	typedef struct packed {
		logic [7:0]  data;
		logic [31:0] offset;
		logic        last;
		logic        status;
		logic        ovf;
	} enc_beat_t;

	enc_beat_t   expected_beats [$];
	enc_beat_t   want;
	logic [31:0] capacity;
	logic [31:0] write_pos;
	logic        sticky_ovf;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h",
			$time, what, got, exp_val);
		mismatch_count++;
	endtask

	// Encode one value and queue the beats it must produce.
	task automatic predict_beats(input logic [31:0] v);
		logic [31:0] mag;
		logic [7:0]  enc [5];
		int          len;
		logic [32:0] end_pos;
		enc_beat_t   b;
		mag = v[31] ? (~v + 32'd1) : v;
		enc[0] = (mag[7:0] & FIRST_MASK) | (v[31] ? SIGN_FLAG : 8'h00);
		mag = mag >> 6;
		len = 1;
		while (mag != 32'd0) begin
			enc[len-1] = enc[len-1] | MORE_FLAG;
			enc[len] = mag[7:0] & NEXT_MASK;
			mag = mag >> 7;
			len++;
		end
		// full-width sum, so the fit test cannot wrap
		end_pos = {1'b0, write_pos} + 33'(len);
		if (end_pos > {1'b0, capacity}) begin
			sticky_ovf = 1'b1;
			b = '{data: 8'h00, offset: write_pos, last: 1'b1, status: 1'b1, ovf: 1'b1};
			expected_beats.push_back(b);
		end else begin
			for (int k = 0; k < len; k++) begin
				b.data   = enc[k];
				b.offset = write_pos + 32'(k);
				b.last   = (k == len - 1);
				b.status = 1'b0;
				b.ovf    = sticky_ovf;
				expected_beats.push_back(b);
			end
			write_pos = write_pos + 32'(len);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			capacity       = CAPACITY_RST;
			write_pos      = 32'd0;
			sticky_ovf     = 1'b0;
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (in_valid && !in_stall)
				predict_beats(value);
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat at offset", byte_offset, 32'd0);
				end else begin
					want = expected_beats.pop_front();
					if (out_byte !== want.data)
						report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
					if (byte_offset !== want.offset)
						report_mismatch("byte_offset", byte_offset, want.offset);
					if (last !== want.last)
						report_mismatch("last", 32'(last), 32'(want.last));
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (overflow_seen !== want.ovf)
						report_mismatch("overflow_seen", 32'(overflow_seen), 32'(want.ovf));
				end
			end
		end
		beats_pending = expected_beats.size();
		next_offset   = write_pos;
	end

endmodule

/* dv/tb_top.sv */
// Top of the varint stream writer testbench: clock, reset, value and capacity
// stimulus, output back-pressure and the verdict. Needs the block and
// bvsw_encode_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// worst case is far below this: about 475 items, each with input gap, encoding and output stalls
	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [31:0] CAP_MAX     = 32'hFFFFFFFF;
	localparam int          PHASES      = 6;
	localparam int          PHASE_ITEMS = 75;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [31:0] value     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_byte;
	logic [31:0]        byte_offset;
	logic               last;
	logic               status;
	logic               overflow_seen;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [31:0]        cfg_data  = '0;

	int          mismatch_count;
	int          beats_pending;
	logic [31:0] next_offset;
	int          cycle_count = 0;
	int          stall_run   = 0;
	int          quiet_run   = 0;
	int unsigned stall_pick;

	// every encoded length with its boundaries, and the sign extremes
	logic [31:0] directed_values [19] = '{
		32'h00000000, 32'h00000001, 32'h0000003F, 32'h00000040, 32'hFFFFFFFF,
		32'hFFFFFFC1, 32'hFFFFFFC0, 32'hFFFFFFBF, 32'h00001FFF, 32'h00002000,
		32'h000FFFFF, 32'h00100000, 32'h07FFFFFF, 32'h08000000, 32'h7FFFFFFF,
		32'h80000000, 32'h80000001, 32'hAAAAAAAA, 32'h55555555
	};

	bounded_varint_stream_writer #(
		.VALUE_WIDTH(32)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_offset  (byte_offset),
		.last         (last),
		.status       (status),
		.overflow_seen(overflow_seen),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	bvsw_encode_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_offset   (byte_offset),
		.last          (last),
		.status        (status),
		.overflow_seen (overflow_seen),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatch_count(mismatch_count),
		.beats_pending (beats_pending),
		.next_offset   (next_offset)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL bounded_varint_stream_writer");
			$finish;
		end
	end

	// Output back-pressure: short and long stalls, with quiet stretches between.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else if (quiet_run > 0) begin
			quiet_run <= quiet_run - 1;
			out_stall <= 1'b0;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 55) begin
				out_stall <= 1'b0;
			end else if (stall_pick < 85) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(0, 3);
			end else if (stall_pick < 95) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(10, 40);
			end else begin
				out_stall <= 1'b0;
				quiet_run <= $urandom_range(30, 120);
			end
		end
	end

	function automatic int pick_gap(input logic quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [31:0] random_value();
		int unsigned sel;
		int unsigned nbits;
		logic [31:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			case ($urandom_range(0, 5))
				0: v = 32'h00000000;
				1: v = 32'h7FFFFFFF;
				2: v = 32'h80000000;
				3: v = 32'hFFFFFFFF;
				4: v = 32'h0000003F;
				default: v = 32'hFFFFFFC0;
			endcase
		end else if (sel < 35) begin
			v = $urandom();
		end else begin
			// spread the magnitudes over every encoded length
			nbits = $urandom_range(0, 31);
			v = $urandom() & ((32'd1 << nbits) - 32'd1);
			if ($urandom_range(0, 1) == 1)
				v = -v;
		end
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_value(input logic [31:0] v, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Hold the input until every expected beat has left the block.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (beats_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [31:0] cap);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] cap;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_values[k])
			send_value(directed_values[k], pick_gap(k < 10));

		// zero capacity: the first failure sets the sticky flag
		write_capacity(32'd0);
		send_value(32'd0, 0);
		// two bytes of room: a long value fails, two short ones fill it exactly
		write_capacity(next_offset + 32'd2);
		send_value(32'd8192, 0);
		send_value(32'd5, 0);
		send_value(32'hFFFFFFFB, 0);
		send_value(32'd0, 0);
		// capacity below the current position
		write_capacity(32'd4);
		send_value(32'd1, 0);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: cap = CAP_MAX;
				1: cap = next_offset + $urandom_range(40, 300);
				2: cap = 32'd0;
				3: cap = next_offset + $urandom_range(0, 12);
				4: cap = $urandom();
				default: cap = CAP_MAX;
			endcase
			write_capacity(cap);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == 40)
					wait_idle();
				send_value(random_value(), pick_gap(((i / 15) % 4) == 0));
			end
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("PASS bounded_varint_stream_writer");
		else
			$display("FAIL bounded_varint_stream_writer");
		$finish;
	end

endmodule
